/* sv/chat_word_blocklist_matcher_macros.svh */
// ----------------------------------------------------------------------------
// Chat word blocklist matcher assertion macros
// Shared assertion forms for the blocklist matcher modules.
// ----------------------------------------------------------------------------
`ifndef CHAT_WORD_BLOCKLIST_MATCHER_MACROS_SVH
`define CHAT_WORD_BLOCKLIST_MATCHER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CWBM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cwbm same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CWBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cwbm next-cycle check failed");

`endif

/* sv/cwbm_pkg.sv */
// ----------------------------------------------------------------------------
// Chat word blocklist matcher package
// Item types, register indexes and character constants.
// ----------------------------------------------------------------------------
package cwbm_pkg;

  localparam int CHAR_W    = 8;
  localparam int SENDER_W  = 4;
  localparam int WIN_W     = 64;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [CHAR_W-1:0] UPPER_A     = 8'h41;
  localparam logic [CHAR_W-1:0] UPPER_Z     = 8'h5A;
  localparam logic [CHAR_W-1:0] LOWER_A     = 8'h61;
  localparam logic [CHAR_W-1:0] LOWER_Z     = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PREFIX_PATTERN_A = 3'd0,
    CFG_PREFIX_MASK_A    = 3'd1,
    CFG_PREFIX_PATTERN_B = 3'd2,
    CFG_PREFIX_MASK_B    = 3'd3,
    CFG_WHOLE_WORD_A     = 3'd4,
    CFG_WHOLE_WORD_B     = 3'd5,
    CFG_WHOLE_WORD_C     = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [CHAR_W-1:0]   char_byte;
    logic [SENDER_W-1:0] sender_id;
    logic                last_byte;
  } in_item_t;

  typedef struct packed {
    logic hit_so_far;
    logic sender_blocked;
    logic message_done;
  } out_item_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

endpackage

/* sv/cwbm_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cwbm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/cwbm_scan.sv */
// ----------------------------------------------------------------------------
// Chat word blocklist matcher scanner
// Pattern registers, letter window and per-message hit tracking.
// ----------------------------------------------------------------------------
`include "chat_word_blocklist_matcher_macros.svh"

module cwbm_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  cwbm_pkg::cfg_wr_t  cfg,
  input  logic               accept,
  input  cwbm_pkg::in_item_t item,
  output logic               msg_hit
);
  import cwbm_pkg::*;

  logic [CFG_W-1:0] pat_a_r, mask_a_r, pat_b_r, mask_b_r;
  logic [CFG_W-1:0] word_a_r, word_b_r, word_c_r;
  logic [WIN_W-1:0] win_r, win_nxt;
  logic             hit_r, hit_nxt;
  logic             stopped_r, stopped_nxt;

  logic [CHAR_W-1:0] folded;
  logic              is_letter;
  logic [WIN_W-1:0]  shifted;
  logic [WIN_W-1:0]  close_win;
  logic              prefix_match;
  logic              close_en;
  logic              word_match;
  logic              active;

  always_comb begin
    folded = item.char_byte;
    if (item.char_byte >= UPPER_A && item.char_byte <= UPPER_Z) begin
      folded = item.char_byte + CASE_OFFSET;
    end
    is_letter    = (folded >= LOWER_A) && (folded <= LOWER_Z);
    shifted      = {win_r[WIN_W-CHAR_W-1:0], folded};
    prefix_match = ((shifted & mask_a_r) == pat_a_r) || ((shifted & mask_b_r) == pat_b_r);
    if (is_letter) begin
      close_win = shifted;
      close_en  = item.last_byte && !prefix_match;
    end else begin
      close_win = win_r;
      close_en  = 1'b1;
    end
    word_match = (close_win != '0) &&
                 ((close_win == word_a_r) || (close_win == word_b_r) ||
                  (close_win == word_c_r));
    active  = !stopped_r && !hit_r;
    msg_hit = hit_r | (active & ((is_letter & prefix_match) | (close_en & word_match)));

    win_nxt     = win_r;
    stopped_nxt = stopped_r;
    hit_nxt     = msg_hit;
    if (active) begin
      win_nxt     = is_letter ? shifted : '0;
      stopped_nxt = (item.char_byte == '0);
    end
    if (item.last_byte) begin
      win_nxt     = '0;
      stopped_nxt = 1'b0;
      hit_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_a_r   <= '1;
      mask_a_r  <= '0;
      pat_b_r   <= '1;
      mask_b_r  <= '0;
      word_a_r  <= '0;
      word_b_r  <= '0;
      word_c_r  <= '0;
      win_r     <= '0;
      hit_r     <= 1'b0;
      stopped_r <= 1'b0;
    end else begin
      if (cfg.we) begin
        unique case (cfg_reg_e'(cfg.idx))
          CFG_PREFIX_PATTERN_A: pat_a_r  <= cfg.data;
          CFG_PREFIX_MASK_A:    mask_a_r <= cfg.data;
          CFG_PREFIX_PATTERN_B: pat_b_r  <= cfg.data;
          CFG_PREFIX_MASK_B:    mask_b_r <= cfg.data;
          CFG_WHOLE_WORD_A:     word_a_r <= cfg.data;
          CFG_WHOLE_WORD_B:     word_b_r <= cfg.data;
          CFG_WHOLE_WORD_C:     word_c_r <= cfg.data;
          default: ;
        endcase
      end
      if (accept) begin
        win_r     <= win_nxt;
        hit_r     <= hit_nxt;
        stopped_r <= stopped_nxt;
      end
    end
  end

  `CWBM_ASSERT_NEXT(a_last_clears, accept && item.last_byte,
                    win_r == '0 && !hit_r && !stopped_r)
  `CWBM_ASSERT_NEXT(a_hit_sticky, accept && hit_r && !item.last_byte, hit_r)
  `CWBM_ASSERT_SAME(a_hit_freezes_window, hit_r && accept && !item.last_byte,
                    win_nxt == win_r)

endmodule

/* sv/chat_word_blocklist_matcher.sv */
// ----------------------------------------------------------------------------
// Chat word blocklist matcher
// Scans message bytes against prefix and whole-word patterns and keeps
// a sticky blocked flag per sender in a small RAM.
// ----------------------------------------------------------------------------
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | char_byte, sender_id, last_byte
//   out_    | output    | out_valid/out_stall | hit_so_far, sender_blocked, message_done
//   cfg_    | input     | cfg_we              | cfg_idx, cfg_wdata
//
// One item is accepted per cycle unless stalled; its result passes the flag
// stage and the output register. The scan state updates at acceptance, and
// the flag RAM is read and set in the same cycle, so the sender flag is
// valid in the following stage. After reset the flag RAM is cleared one
// entry per cycle, all SENDERS entries, with in_stall held high. A stalled
// output holds one result while one more item waits in the flag stage.
// ----------------------------------------------------------------------------
`include "chat_word_blocklist_matcher_macros.svh"

module chat_word_blocklist_matcher #(
  parameter int SENDERS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cwbm_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [cwbm_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  cwbm_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output cwbm_pkg::out_item_t                 out_data
);
  import cwbm_pkg::*;

  localparam int SND_W = $clog2(SENDERS);
  localparam logic [SND_W-1:0] LAST_IDX = SND_W'(SENDERS - 1);

  cfg_wr_t    cfg;
  logic       accept;
  logic       msg_hit;
  logic [31:0] snd_ext;
  logic       snd_ok;
  logic [SND_W-1:0] snd_idx;

  logic             clearing_r;
  logic [SND_W-1:0] clr_idx_r;

  logic       ram_we;
  logic [SND_W-1:0] ram_waddr;
  logic       ram_wdata;
  logic       ram_q;

  logic       s1_valid_r, s1_hit_r, s1_ok_r, s1_last_r;
  logic       s1_adv;
  logic       s1_blocked;
  logic       out_valid_r;
  out_item_t  out_data_r;

  assign cfg = '{we: cfg_we, idx: cfg_idx, data: cfg_wdata};

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = clearing_r || (s1_valid_r && !s1_adv);
  assign accept   = in_valid && !in_stall;

  assign snd_ext = 32'(in_data.sender_id);
  assign snd_ok  = snd_ext < 32'(SENDERS);
  assign snd_idx = snd_ext[SND_W-1:0];

  cwbm_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .accept  (accept),
    .item    (in_data),
    .msg_hit (msg_hit)
  );

  assign ram_we    = clearing_r || (accept && snd_ok && msg_hit);
  assign ram_waddr = clearing_r ? clr_idx_r : snd_idx;
  assign ram_wdata = !clearing_r;

  cwbm_ram #(
    .WIDTH (1),
    .DEPTH (SENDERS)
  ) u_flags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (snd_idx),
    .rdata (ram_q)
  );

  assign s1_blocked = s1_ok_r && (ram_q || s1_hit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_idx_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_idx_r <= clr_idx_r + SND_W'(1);
        if (clr_idx_r == LAST_IDX) begin
          clearing_r <= 1'b0;
        end
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hit_r  <= msg_hit;
      s1_ok_r   <= snd_ok;
      s1_last_r <= in_data.last_byte;
    end
    if (s1_adv) begin
      out_data_r <= '{hit_so_far: s1_hit_r, sender_blocked: s1_blocked,
                      message_done: s1_last_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CWBM_ASSERT_SAME(a_clear_empty, clearing_r, !s1_valid_r && !out_valid_r && !accept)
  `CWBM_ASSERT_SAME(a_hit_blocks, s1_valid_r && s1_ok_r && s1_hit_r, s1_blocked)
  `CWBM_ASSERT_SAME(a_flag_write_src, ram_we && !clearing_r, accept && snd_ok && msg_hit)

endmodule

/* tb/tb_chat_word_blocklist_matcher.sv */
// ----------------------------------------------------------------------------
// Chat word blocklist matcher testbench
// Streams chat messages through the matcher under several pattern settings.
// A scoreboard predicts the hit and blocked flags of every byte, and random
// gaps and stalls are applied on both sides.
// ----------------------------------------------------------------------------
class verdict_scoreboard;
  logic [63:0] prefix_pat_a = '1;
  logic [63:0] prefix_msk_a = '0;
  logic [63:0] prefix_pat_b = '1;
  logic [63:0] prefix_msk_b = '0;
  logic [63:0] word_a = '0;
  logic [63:0] word_b = '0;
  logic [63:0] word_c = '0;
  logic [63:0] window = '0;
  bit msg_hit;
  bit scan_off;
  bit blocked [1 << cwbm_pkg::SENDER_W];
  cwbm_pkg::out_item_t expected_verdicts[$];
  int verdicts_seen;
  int errors;

  function void set_reg(cwbm_pkg::cfg_reg_e r, logic [63:0] v);
    case (r)
      cwbm_pkg::CFG_PREFIX_PATTERN_A: prefix_pat_a = v;
      cwbm_pkg::CFG_PREFIX_MASK_A:    prefix_msk_a = v;
      cwbm_pkg::CFG_PREFIX_PATTERN_B: prefix_pat_b = v;
      cwbm_pkg::CFG_PREFIX_MASK_B:    prefix_msk_b = v;
      cwbm_pkg::CFG_WHOLE_WORD_A:     word_a = v;
      cwbm_pkg::CFG_WHOLE_WORD_B:     word_b = v;
      cwbm_pkg::CFG_WHOLE_WORD_C:     word_c = v;
      default: ;
    endcase
  endfunction

  function void close_word();
    if (window != '0) begin
      if (window == word_a || window == word_b || window == word_c) msg_hit = 1'b1;
      window = '0;
    end
  endfunction

  function void note_char(cwbm_pkg::in_item_t it);
    logic [7:0] c;
    cwbm_pkg::out_item_t v;
    c = it.char_byte;
    if (!scan_off && !msg_hit) begin
      if (c == 8'h00) begin
        close_word();
        scan_off = 1'b1;
      end else begin
        if (c >= cwbm_pkg::UPPER_A && c <= cwbm_pkg::UPPER_Z) c = c + cwbm_pkg::CASE_OFFSET;
        if (c >= cwbm_pkg::LOWER_A && c <= cwbm_pkg::LOWER_Z) begin
          window = {window[55:0], c};
          if ((window & prefix_msk_a) == prefix_pat_a ||
              (window & prefix_msk_b) == prefix_pat_b) msg_hit = 1'b1;
        end else begin
          close_word();
        end
      end
      if (it.last_byte && !msg_hit) close_word();
    end
    if (msg_hit) blocked[it.sender_id] = 1'b1;
    v.hit_so_far = msg_hit;
    v.sender_blocked = blocked[it.sender_id];
    v.message_done = it.last_byte;
    expected_verdicts.push_back(v);
    if (it.last_byte) begin
      window = '0;
      msg_hit = 1'b0;
      scan_off = 1'b0;
    end
  endfunction

  function void check_verdict(cwbm_pkg::out_item_t got);
    cwbm_pkg::out_item_t exp;
    verdicts_seen++;
    if (expected_verdicts.size() == 0) begin
      $error("unexpected result %b with no item pending", got);
      errors++;
      return;
    end
    exp = expected_verdicts.pop_front();
    if (exp.hit_so_far !== got.hit_so_far) begin
      $error("hit_so_far: expected %0b, got %0b", exp.hit_so_far, got.hit_so_far);
      errors++;
    end
    if (exp.sender_blocked !== got.sender_blocked) begin
      $error("sender_blocked: expected %0b, got %0b", exp.sender_blocked, got.sender_blocked);
      errors++;
    end
    if (exp.message_done !== got.message_done) begin
      $error("message_done: expected %0b, got %0b", exp.message_done, got.message_done);
      errors++;
    end
  endfunction
endclass

module tb_chat_word_blocklist_matcher;
  timeunit 1ns;
  timeprecision 1ps;
  import cwbm_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int SENDER_COUNT = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_PAD = 6;
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 250;
  localparam logic [7:0] NUL_CHAR = 8'h00;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [63:0] SIX_LETTER_MASK = 64'h0000_FFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_PREFIX_PATTERN_A;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  verdict_scoreboard sb;
  string lexicon[$];
  int items_offered = 0;
  int send_calm = 0;
  int take_calm = 0;
  int results_taken = 0;
  int cycle_count = 0;

  chat_word_blocklist_matcher #(.SENDERS(SENDER_COUNT)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_char(in_data);
      if (out_valid && !out_stall) sb.check_verdict(out_data);
    end
  end

  function int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(20, 60);
    return $urandom_range(0, 15);
  endfunction

  function automatic logic [63:0] pack_word(string s);
    logic [63:0] w;
    logic [7:0] c;
    w = '0;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= UPPER_A && c <= UPPER_Z) c = c + CASE_OFFSET;
      w = {w[55:0], c};
    end
    return w;
  endfunction

  function automatic logic [63:0] byte_mask(int n);
    if (n >= 8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic string random_word(int len);
    string s;
    s = "";
    repeat (len) s = $sformatf("%s%c", s, 8'(LOWER_A + $urandom_range(0, 25)));
    return s;
  endfunction

  function automatic byte_q_t text_bytes(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [7:0] random_separator();
    case ($urandom_range(0, 7))
      0, 1: return SPACE_CHAR;
      2: return 8'($urandom_range(SPACE_CHAR + 1, UPPER_A - 1));
      3: return 8'($urandom_range(UPPER_Z + 1, LOWER_A - 1));
      4: return 8'($urandom_range(LOWER_Z + 1, 255));
      5: return 8'($urandom_range(1, SPACE_CHAR - 1));
      6: return NUL_CHAR;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic byte_q_t random_message();
    byte_q_t msg;
    string w;
    int n_words;
    logic [7:0] c;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 10)) msg.push_back(8'($urandom_range(0, 255)));
      return msg;
    end
    n_words = $urandom_range(1, 5);
    for (int k = 0; k < n_words; k++) begin
      if (lexicon.size() > 0 && $urandom_range(0, 1) == 1)
        w = lexicon[$urandom_range(0, lexicon.size() - 1)];
      else
        w = random_word($urandom_range(1, 12));
      for (int i = 0; i < w.len(); i++) begin
        c = w[i];
        if ($urandom_range(0, 3) == 0) c = c - CASE_OFFSET;
        msg.push_back(c);
      end
      if (k < n_words - 1 || $urandom_range(0, 1) == 1) msg.push_back(random_separator());
    end
    return msg;
  endfunction

  task automatic offer_item(in_item_t it);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_offered++;
  endtask

  task automatic send_bytes(byte_q_t msg, logic [3:0] sid, bit mix);
    in_item_t it;
    for (int i = 0; i < msg.size(); i++) begin
      it.char_byte = msg[i];
      it.sender_id = (mix && $urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : sid;
      it.last_byte = (i == msg.size() - 1);
      offer_item(it);
    end
  endtask

  task automatic run_messages(int n);
    byte_q_t msg;
    int count;
    count = 0;
    while (count < n) begin
      msg = random_message();
      send_bytes(msg, 4'($urandom_range(0, 15)), 1'b1);
      count += msg.size();
    end
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (sb.verdicts_seen < items_offered) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic put_reg(cfg_reg_e r, logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= r;
    cfg_wdata <= v;
    sb.set_reg(r, v);
    @(posedge clk);
  endtask

  task automatic apply_setting(logic [63:0] pa, logic [63:0] ma, logic [63:0] pb,
                               logic [63:0] mb, logic [63:0] wa, logic [63:0] wb,
                               logic [63:0] wc);
    put_reg(CFG_PREFIX_PATTERN_A, pa);
    put_reg(CFG_PREFIX_MASK_A, ma);
    put_reg(CFG_PREFIX_PATTERN_B, pb);
    put_reg(CFG_PREFIX_MASK_B, mb);
    put_reg(CFG_WHOLE_WORD_A, wa);
    put_reg(CFG_WHOLE_WORD_B, wb);
    put_reg(CFG_WHOLE_WORD_C, wc);
    cfg_we <= 1'b0;
  endtask

  task automatic send_directed();
    send_bytes(text_bytes("BAD"), 4'd15, 1'b0);
    send_bytes(text_bytes("spam!x"), 4'd0, 1'b0);
    send_bytes({8'h78, NUL_CHAR, 8'h42, 8'h41, 8'h44}, 4'd3, 1'b0);
    send_bytes({8'hFF, 8'h62, 8'h61, 8'h64, 8'h80}, 4'd9, 1'b0);
    send_bytes(text_bytes("cHeatz"), 4'd12, 1'b0);
  endtask

  task automatic run_random_setting();
    string w1, w2, w3, w4, w5, w6, w7;
    logic [63:0] mb;
    w1 = random_word($urandom_range(2, 6));
    w2 = random_word($urandom_range(3, 8));
    w3 = random_word($urandom_range(1, 8));
    w4 = random_word($urandom_range(1, 8));
    w5 = random_word($urandom_range(1, 8));
    w6 = $sformatf("q%s", w3);
    w7 = $sformatf("%ss", w1);
    mb = byte_mask(w2.len()) & {$urandom, $urandom};
    apply_setting(pack_word(w1), byte_mask(w1.len()), pack_word(w2) & mb, mb,
                  pack_word(w3), pack_word(w4), pack_word(w5));
    lexicon = {w1, w2, w3, w4, w5, w6, w7};
    run_messages(230);
    settle_block();
  endtask

  initial begin
    int n;
    forever begin
      n = (results_taken == HOLD_AFTER) ? HOLD_CYCLES : draw_wait(take_calm);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      results_taken++;
    end
  end

  initial begin
    sb = new;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    lexicon = {"bad", "cheat", "zz"};
    run_messages(280);
    settle_block();

    apply_setting(pack_word("cheat"), byte_mask(5), pack_word("hacker"), SIX_LETTER_MASK,
                  pack_word("bad"), pack_word("spam"), pack_word("abcdefgh"));
    send_directed();
    lexicon = {"cheat", "cheaters", "hacker", "hack", "bad", "badly", "spam", "sp",
               "abcdefgh", "xabcdefgh", "abcdefg", "hello", "game"};
    run_messages(270);
    settle_block();

    apply_setting('0, '0, '1, '1, '1, '1, '1);
    lexicon = {};
    run_messages(200);
    settle_block();

    apply_setting('1, '1, '0, '1, '1, pack_word("zzzzzzzz"), pack_word("a"));
    lexicon = {"zzzzzzzz", "a", "zz", "azzzzzzzz", "aa"};
    run_messages(250);
    settle_block();

    run_random_setting();
    run_random_setting();

    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
